FILE: sv/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths, command and register codes, and the control word that
// steers the multiply-accumulate unit of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 35;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // One step of the dot product: operands present, first term, last term.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

FILE: sv/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// Shared multiply-accumulate unit: one registered product per cycle, summed
// at full precision, with the total saturated to the result width.
// ----------------------------------------------------------------------------
module mme_mac #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mme_pkg::mac_ctrl_t               ctrl,
  input  logic signed [ELEMENT_WIDTH-1:0]  a,
  input  logic signed [ELEMENT_WIDTH-1:0]  b,
  output logic                             done,
  output logic signed [mme_pkg::SUM_W-1:0] result
);
  import mme_pkg::*;

  localparam int PROD_W = 2 * ELEMENT_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam int WIDE_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam logic signed [WIDE_W-1:0] SAT_HI =
    WIDE_W'(signed'({1'b0, {(SUM_W-1){1'b1}}}));
  localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [PROD_W-1:0] prod;
  mac_ctrl_t                prod_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [WIDE_W-1:0] acc_wide;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (prod_ctrl.valid) begin
      acc <= prod_ctrl.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (rst) begin
      prod_ctrl <= '0;
      done      <= 1'b0;
    end else begin
      prod_ctrl <= ctrl;
      done      <= prod_ctrl.valid && prod_ctrl.last;
    end
  end

  // Saturation only bites when the accumulator is wider than SUM_W.
  always_comb begin
    acc_wide = WIDE_W'(acc);
    if (acc_wide > SAT_HI) begin
      result = SUM_W'(SAT_HI);
    end else if (acc_wide < SAT_LO) begin
      result = SUM_W'(SAT_LO);
    end else begin
      result = SUM_W'(acc_wide);
    end
  end

endmodule

FILE: sv/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Integer matrix multiply C = A x B on matrices held in two small RAMs,
// loaded one element per transaction and swept by a shared MAC unit.
//
//   Channel   Handshake                  Payload
//   item      item_valid / item_ready    command, row_index, col_index,
//                                        element_value
//   result    result_valid / result_ready out_row, out_col, product_value,
//                                        status, last_result
//   cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each result element needs one RAM read per inner term, then passes
// through the RAM output, product and accumulator registers. item_ready
// is low for the whole compute; a stalled result holds the sequencer.
// Reset sets the three dimension registers to 8; RAM contents are
// undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic [mme_pkg::CMD_W-1:0]            command,
  input  logic [mme_pkg::IDX_W-1:0]            row_index,
  input  logic [mme_pkg::IDX_W-1:0]            col_index,
  input  logic signed [mme_pkg::VAL_W-1:0]     element_value,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [mme_pkg::IDX_W-1:0]            out_row,
  output logic [mme_pkg::IDX_W-1:0]            out_col,
  output logic signed [mme_pkg::SUM_W-1:0]     product_value,
  output logic                                 status,
  output logic                                 last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]            cfg_data
);
  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    logic [2*IDX_W:0] full;
    full = (2*IDX_W+1)'(r) * (2*IDX_W+1)'(MAX_DIM) + (2*IDX_W+1)'(c);
    return ADDR_W'(full);
  endfunction

  logic [1:0]       state;
  logic [DIM_W-1:0] left_rows, inner_size, right_cols;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [IDX_W-1:0] i_cnt, j_cnt, k_cnt;
  logic             acc_done;
  mac_ctrl_t        issue_ctrl;

  logic                            item_take;
  logic                            is_load, is_load_a, range_ok, load_bad, load_we;
  logic [DIM_W-1:0]                row_lim, col_lim;
  logic [ADDR_W-1:0]               load_addr, a_raddr, b_raddr;
  logic signed [ELEMENT_WIDTH-1:0] load_data;
  logic signed [ELEMENT_WIDTH-1:0] a_rdata, b_rdata;
  logic                            issue, k_last, i_last, j_last;
  logic                            out_free, res_avail, res_load;
  logic                            mac_done;
  logic signed [SUM_W-1:0]         mac_result;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);
  assign item_take  = item_valid && item_ready;

  assign nr = clamp_dim(left_rows);
  assign nk = clamp_dim(inner_size);
  assign nc = clamp_dim(right_cols);

  assign is_load   = (command == CMD_LOAD_A) || (command == CMD_LOAD_B);
  assign is_load_a = (command == CMD_LOAD_A);
  assign row_lim   = is_load_a ? nr : nk;
  assign col_lim   = is_load_a ? nk : nc;
  assign range_ok  = ({1'b0, row_index} < row_lim) && ({1'b0, col_index} < col_lim);
  assign load_bad  = item_take && is_load && !range_ok;
  assign load_we   = item_take && is_load && range_ok;
  assign load_addr = elem_addr(row_index, col_index);
  assign load_data = ELEMENT_WIDTH'(element_value);

  assign issue   = (state == ST_MAC);
  assign a_raddr = elem_addr(i_cnt, k_cnt);
  assign b_raddr = elem_addr(k_cnt, j_cnt);
  assign k_last  = (DIM_W'(k_cnt) + DIM_W'(1)) == nk;
  assign i_last  = (DIM_W'(i_cnt) + DIM_W'(1)) == nr;
  assign j_last  = (DIM_W'(j_cnt) + DIM_W'(1)) == nc;

  assign out_free  = !result_valid || result_ready;
  assign res_avail = acc_done || mac_done;
  assign res_load  = (state == ST_WAIT) && res_avail && out_free;

  mme_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_left_ram (
    .clk  (clk),
    .we   (load_we && is_load_a),
    .waddr(load_addr),
    .wdata(load_data),
    .re   (issue),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  mme_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_right_ram (
    .clk  (clk),
    .we   (load_we && !is_load_a),
    .waddr(load_addr),
    .wdata(load_data),
    .re   (issue),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  mme_mac #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (issue_ctrl),
    .a     (a_rdata),
    .b     (b_rdata),
    .done  (mac_done),
    .result(mac_result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows  <= DIM_W'(8);
      inner_size <= DIM_W'(8);
      right_cols <= DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_ROWS:  left_rows  <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_RIGHT_COLS: right_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: one dot product at a time through the shared MAC.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      i_cnt      <= '0;
      j_cnt      <= '0;
      k_cnt      <= '0;
      acc_done   <= 1'b0;
      issue_ctrl <= '0;
    end else begin
      issue_ctrl.valid <= issue;
      issue_ctrl.first <= (k_cnt == '0);
      issue_ctrl.last  <= k_last;

      if (res_load) begin
        acc_done <= 1'b0;
      end else if (mac_done) begin
        acc_done <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (item_take) begin
            case (command)
              CMD_LOAD_A, CMD_LOAD_B: begin
                if (!range_ok && !out_free) begin
                  state <= ST_ERR;
                end
              end
              CMD_COMPUTE: begin
                i_cnt <= '0;
                j_cnt <= '0;
                k_cnt <= '0;
                state <= ST_MAC;
              end
              default: ;
            endcase
          end
        end
        ST_ERR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_MAC: begin
          if (k_last) begin
            k_cnt <= '0;
            state <= ST_WAIT;
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (res_load) begin
            if (i_last && j_last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_MAC;
              if (j_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + IDX_W'(1);
              end else begin
                j_cnt <= j_cnt + IDX_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_row       <= i_cnt;
      out_col       <= j_cnt;
      product_value <= mac_result;
      status        <= STATUS_OK;
      last_result   <= i_last && j_last;
    end else if ((load_bad && out_free) || (state == ST_ERR && out_free)) begin
      out_row       <= '0;
      out_col       <= '0;
      product_value <= '0;
      status        <= STATUS_RANGE;
      last_result   <= 1'b1;
    end
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load || ((load_bad || state == ST_ERR) && out_free)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_WAIT))
    else $error("MAC finished outside the wait state");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> ({1'b0, k_cnt} < nk))
    else $error("inner counter ran past the inner size");

  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == STATUS_RANGE) |-> (product_value == '0 && last_result))
    else $error("range error result carries a nonzero payload");

  a_wait_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && mac_done && out_free) |=> result_valid)
    else $error("finished dot product was not moved to the result register");

endmodule
